// ===== rtl/core/msa_pkg.sv =====
// -----------------------------------------------------------------------------
// msa_pkg
// Shared widths and codes for the muxed ADC scan averager.
// -----------------------------------------------------------------------------
package msa_pkg;

   // request and response field widths
   localparam int SAMPLE_W   = 12;
   localparam int AVG_W      = 10;
   localparam int SLOT_IDX_W = 6;
   localparam int SEL_W      = 3;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KIND_MAP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_ENABLE = 2'd1;

   // channel kinds, two bits per channel in the kind map
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MUXED  = 2'd2;

   // the kind map describes this many channels; later ones are unused
   localparam int MAP_CHANNELS = 16;
   localparam int MAP_POS_W    = 5;

   // multiplexer stepping
   localparam logic [SEL_W-1:0] MUX_LAST = 3'd7;

   // per-scan channel counters and the raw slot number they produce
   localparam int SEEN_W = 5;
   localparam int SLOT_W = 8;

endpackage

// ===== rtl/core/msa_req_if.sv =====
// -----------------------------------------------------------------------------
// msa_req_if
// Request channel: one converter reading per transfer.
// -----------------------------------------------------------------------------
interface msa_req_if;

   logic                          valid;
   logic                          ready;
   logic [msa_pkg::SAMPLE_W-1:0]  raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);

endinterface

// ===== rtl/core/msa_rsp_if.sv =====
// -----------------------------------------------------------------------------
// msa_rsp_if
// Response channel: slot update result and scan status for each request.
// -----------------------------------------------------------------------------
interface msa_rsp_if;

   logic                            valid;
   logic                            ready;
   logic                            slot_written;
   logic [msa_pkg::SLOT_IDX_W-1:0]  slot_index;
   logic [msa_pkg::AVG_W-1:0]       slot_average;
   logic                            index_overflow;
   logic                            scan_done;
   logic [msa_pkg::SEL_W-1:0]       mux_select;

   modport source (
      output valid, output slot_written, output slot_index, output slot_average,
      output index_overflow, output scan_done, output mux_select, input ready
   );
   modport sink (
      input valid, input slot_written, input slot_index, input slot_average,
      input index_overflow, input scan_done, input mux_select, output ready
   );

endinterface

// ===== rtl/core/msa_ram.sv =====
// -----------------------------------------------------------------------------
// msa_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// -----------------------------------------------------------------------------
module msa_ram #(
   parameter int WIDTH  = 10,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/muxed_adc_scan_averager.sv =====
// -----------------------------------------------------------------------------
// muxed_adc_scan_averager
// Per-slot boxcar average of scanned ADC readings, direct and multiplexed.
// -----------------------------------------------------------------------------
//
//   channel | direction | handshake          | carries
//   --------+-----------+--------------------+------------------------------------
//   req_ch  | in        | valid / ready      | raw_sample
//   rsp_ch  | out       | valid / ready      | slot result, scan_done, mux_select
//   csr_*   | in        | csr_we, no ready   | kind map (index 0), enable (index 1)
//
// One request per cycle sustained while responses are taken; a response
// passes the middle stage, then the response register. Ring and sum memories
// are read when a request is taken and written as it leaves the middle stage,
// so throughput is set by that single read/modify/write pass through the two
// RAMs (last write is forwarded). After reset a clearing pass over every ring
// address zeroes both memories; no request is taken during it. A stalled
// response holds the middle stage, which a new request still enters if empty.
// -----------------------------------------------------------------------------
module muxed_adc_scan_averager #(
   parameter int CHANNELS  = 16,
   parameter int SIGNALS   = 64,
   parameter int BUF_DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   msa_req_if.sink                          req_ch,
   msa_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [msa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // ---------------------------------------------------------------------------
   // Derived sizes
   // ---------------------------------------------------------------------------
   localparam int POS_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int COL_W      = $clog2(BUF_DEPTH);
   localparam int RING_DEPTH = SIGNALS * BUF_DEPTH;
   localparam int ADDR_W     = $clog2(RING_DEPTH);
   localparam int SIG_W      = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;
   localparam int SMP_W      = msa_pkg::AVG_W;
   // running sum holds up to BUF_DEPTH full-scale samples
   localparam int SUM_W      = $clog2(((1 << SMP_W) - 1) * BUF_DEPTH + 1);
   // floor(sum / BUF_DEPTH) as (sum * RECIP) >> RECIP_SH, exact for every sum
   localparam int RECIP_SH   = SUM_W + $clog2(BUF_DEPTH);
   localparam int RECIP      = ((1 << RECIP_SH) + BUF_DEPTH - 1) / BUF_DEPTH;
   localparam int PROD_W     = RECIP_SH + SMP_W + 1;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [msa_pkg::CSR_DATA_W-1:0] kind_map_ff, kind_map_in;
   logic                           scan_en_ff, scan_en_in;

   always_comb begin
      kind_map_in = kind_map_ff;
      scan_en_in  = scan_en_ff;
      if (csr_we) begin
         case (csr_index)
            msa_pkg::CSR_KIND_MAP:    kind_map_in = csr_wdata;
            msa_pkg::CSR_SCAN_ENABLE: scan_en_in  = csr_wdata[0];
            default:                  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_map_ff <= '0;
         scan_en_ff  <= 1'b1;
      end else begin
         kind_map_ff <= kind_map_in;
         scan_en_ff  <= scan_en_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Clearing pass over both memories after reset
   // ---------------------------------------------------------------------------
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(RING_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline handshake
   // ---------------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;   // middle stage moves into the response register
   logic req_fire;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !clr_busy_ff && (!s1_valid_ff || advance);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // ---------------------------------------------------------------------------
   // Request stage: scan position, slot number and memory addresses
   // ---------------------------------------------------------------------------
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [msa_pkg::SEEN_W-1:0] muxed_seen_ff, muxed_seen_in;
   logic [msa_pkg::SEEN_W-1:0] direct_seen_ff, direct_seen_in;
   logic [msa_pkg::SEL_W-1:0]  mux_step_ff, mux_step_in;
   logic [COL_W-1:0]           dcol_ff, dcol_in;
   logic [COL_W-1:0]           mcol_ff, mcol_in;

   logic [msa_pkg::MAP_POS_W-1:0] pos_ext;
   logic [msa_pkg::KIND_W-1:0]    kind;
   logic                          is_direct;
   logic                          is_muxed;
   logic [msa_pkg::SLOT_W-1:0]    slot;
   logic [COL_W-1:0]              col;
   logic                          in_range;
   logic                          scan_end;
   logic [ADDR_W-1:0]             ring_raddr;
   logic [SIG_W-1:0]              sum_raddr;

   always_comb begin
      pos_ext = msa_pkg::MAP_POS_W'(pos_ff);
      // positions past the map's reach count as unused
      if (pos_ext >= msa_pkg::MAP_POS_W'(msa_pkg::MAP_CHANNELS)) begin
         kind = msa_pkg::KIND_UNUSED;
      end else begin
         kind = kind_map_ff[{pos_ext[msa_pkg::MAP_POS_W-2:0], 1'b0} +: msa_pkg::KIND_W];
      end
      is_direct = (kind == msa_pkg::KIND_DIRECT);
      is_muxed  = (kind == msa_pkg::KIND_MUXED);

      // a slot counts eight per muxed channel and one per direct one seen before it
      slot = {muxed_seen_ff, 3'b000} + msa_pkg::SLOT_W'(direct_seen_ff);
      if (is_muxed) begin
         slot = slot + msa_pkg::SLOT_W'(mux_step_ff);
      end
      col      = is_muxed ? mcol_ff : dcol_ff;
      in_range = ({1'b0, slot} < (msa_pkg::SLOT_W + 1)'(SIGNALS));

      ring_raddr = ADDR_W'(int'(slot) * BUF_DEPTH + int'(col));
      sum_raddr  = SIG_W'(slot);
      scan_end   = (pos_ff == POS_W'(CHANNELS - 1));
   end

   always_comb begin
      pos_in         = pos_ff;
      muxed_seen_in  = muxed_seen_ff;
      direct_seen_in = direct_seen_ff;
      mux_step_in    = mux_step_ff;
      dcol_in        = dcol_ff;
      mcol_in        = mcol_ff;
      if (req_fire && scan_en_ff) begin
         if (scan_end) begin
            // close scan: restart counts, step mux, advance cols (muxed on wrap)
            pos_in         = '0;
            muxed_seen_in  = '0;
            direct_seen_in = '0;
            if (mux_step_ff == msa_pkg::MUX_LAST) begin
               mux_step_in = '0;
               mcol_in     = (mcol_ff == COL_W'(BUF_DEPTH - 1)) ? '0 : mcol_ff + 1'b1;
            end else begin
               mux_step_in = mux_step_ff + 1'b1;
            end
            dcol_in = (dcol_ff == COL_W'(BUF_DEPTH - 1)) ? '0 : dcol_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (is_direct) begin
               direct_seen_in = direct_seen_ff + 1'b1;
            end
            if (is_muxed) begin
               muxed_seen_in = muxed_seen_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         muxed_seen_ff  <= '0;
         direct_seen_ff <= '0;
         mux_step_ff    <= '0;
         dcol_ff        <= '0;
         mcol_ff        <= '0;
      end else begin
         pos_ff         <= pos_in;
         muxed_seen_ff  <= muxed_seen_in;
         direct_seen_ff <= direct_seen_in;
         mux_step_ff    <= mux_step_in;
         dcol_ff        <= dcol_in;
         mcol_ff        <= mcol_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Middle stage registers: one request waiting on its RAM read data
   // ---------------------------------------------------------------------------
   logic                             s1_write_ff, s1_write_in;
   logic                             s1_ovf_ff, s1_ovf_in;
   logic                             s1_done_ff, s1_done_in;
   logic [msa_pkg::SEL_W-1:0]        s1_sel_ff, s1_sel_in;
   logic [msa_pkg::SLOT_W-1:0]       s1_slot_ff, s1_slot_in;
   logic [ADDR_W-1:0]                s1_addr_ff, s1_addr_in;
   logic [SMP_W-1:0]                 s1_sample_ff, s1_sample_in;
   logic                             s1_load;

   assign s1_load = req_fire;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_write_in  = s1_write_ff;
      s1_ovf_in    = s1_ovf_ff;
      s1_done_in   = s1_done_ff;
      s1_sel_in    = s1_sel_ff;
      s1_slot_in   = s1_slot_ff;
      s1_addr_in   = s1_addr_ff;
      s1_sample_in = s1_sample_ff;
      if (!s1_valid_ff || advance) begin
         s1_valid_in = req_fire;
      end
      if (s1_load) begin
         // disabled scan: a request gives an all-zero response and no update
         s1_write_in  = scan_en_ff && (is_direct || is_muxed) && in_range;
         s1_ovf_in    = scan_en_ff && (is_direct || is_muxed) && !in_range;
         s1_done_in   = scan_en_ff && scan_end;
         s1_sel_in    = (scan_en_ff && scan_end) ? mux_step_in : '0;
         s1_slot_in   = slot;
         s1_addr_in   = ring_raddr;
         s1_sample_in = req_ch.raw_sample[SMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_write_ff  <= s1_write_in;
      s1_ovf_ff    <= s1_ovf_in;
      s1_done_ff   <= s1_done_in;
      s1_sel_ff    <= s1_sel_in;
      s1_slot_ff   <= s1_slot_in;
      s1_addr_ff   <= s1_addr_in;
      s1_sample_ff <= s1_sample_in;
   end

   // ---------------------------------------------------------------------------
   // Sample ring and running-sum memories
   // ---------------------------------------------------------------------------
   logic              commit;   // middle stage writes its slot this cycle
   logic              ring_we;
   logic [ADDR_W-1:0] ring_waddr;
   logic [SMP_W-1:0]  ring_wdata;
   logic [SMP_W-1:0]  ring_rdata;
   logic              sum_we;
   logic [SIG_W-1:0]  sum_waddr;
   logic [SUM_W-1:0]  sum_wdata;
   logic [SUM_W-1:0]  sum_rdata;
   logic [SUM_W-1:0]  new_sum;
   logic [SIG_W-1:0]  s1_sum_addr;

   assign commit      = s1_valid_ff && advance && s1_write_ff;
   assign s1_sum_addr = SIG_W'(s1_slot_ff);

   always_comb begin
      if (clr_busy_ff) begin
         ring_we    = 1'b1;
         ring_waddr = clr_addr_ff;
         ring_wdata = '0;
         sum_we     = ({1'b0, clr_addr_ff} < (ADDR_W + 1)'(SIGNALS));
         sum_waddr  = SIG_W'(clr_addr_ff);
         sum_wdata  = '0;
      end else begin
         ring_we    = commit;
         ring_waddr = s1_addr_ff;
         ring_wdata = s1_sample_ff;
         sum_we     = commit;
         sum_waddr  = s1_sum_addr;
         sum_wdata  = new_sum;
      end
   end

   msa_ram #(
      .WIDTH (SMP_W),
      .DEPTH (RING_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_en   (s1_load),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   msa_ram #(
      .WIDTH (SUM_W),
      .DEPTH (SIGNALS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_en   (s1_load),
      .rd_addr (sum_raddr),
      .rd_data (sum_rdata)
   );

   // ---------------------------------------------------------------------------
   // Last committed write, forwarded over a read that raced it
   // ---------------------------------------------------------------------------
   logic              lr_valid_ff, lr_valid_in;
   logic [ADDR_W-1:0] lr_addr_ff;
   logic [SMP_W-1:0]  lr_data_ff;
   logic [SIG_W-1:0]  ls_addr_ff;
   logic [SUM_W-1:0]  ls_data_ff;

   always_comb begin
      lr_valid_in = lr_valid_ff;
      if (clr_busy_ff) begin
         lr_valid_in = 1'b0;
      end else if (commit) begin
         lr_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_valid_ff <= 1'b0;
      end else begin
         lr_valid_ff <= lr_valid_in;
      end
      if (commit) begin
         lr_addr_ff <= s1_addr_ff;
         lr_data_ff <= s1_sample_ff;
         ls_addr_ff <= s1_sum_addr;
         ls_data_ff <= new_sum;
      end
   end

   // ---------------------------------------------------------------------------
   // Update the running sum and take its floor mean
   // ---------------------------------------------------------------------------
   logic [SMP_W-1:0]  old_sample;
   logic [SUM_W-1:0]  old_sum;
   logic [PROD_W-1:0] mean_prod;
   logic [SMP_W-1:0]  mean;

   always_comb begin
      old_sample = (lr_valid_ff && (lr_addr_ff == s1_addr_ff)) ? lr_data_ff : ring_rdata;
      old_sum    = (lr_valid_ff && (ls_addr_ff == s1_sum_addr)) ? ls_data_ff : sum_rdata;
      new_sum    = old_sum - SUM_W'(old_sample) + SUM_W'(s1_sample_ff);
      mean_prod  = PROD_W'(new_sum) * PROD_W'(RECIP);
      mean       = mean_prod[RECIP_SH +: SMP_W];
   end

   // ---------------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------------
   logic                           rsp_written_ff, rsp_written_in;
   logic [msa_pkg::SLOT_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [msa_pkg::AVG_W-1:0]      rsp_avg_ff, rsp_avg_in;
   logic                           rsp_ovf_ff, rsp_ovf_in;
   logic                           rsp_done_ff, rsp_done_in;
   logic [msa_pkg::SEL_W-1:0]      rsp_sel_ff, rsp_sel_in;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_written_in = rsp_written_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_avg_in     = rsp_avg_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_sel_in     = rsp_sel_ff;
      if (advance) begin
         rsp_valid_in   = s1_valid_ff;
         rsp_written_in = s1_write_ff;
         rsp_index_in   = s1_write_ff ? s1_slot_ff[msa_pkg::SLOT_IDX_W-1:0] : '0;
         rsp_avg_in     = s1_write_ff ? mean : '0;
         rsp_ovf_in     = s1_ovf_ff;
         rsp_done_in    = s1_done_ff;
         rsp_sel_in     = s1_sel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_written_ff <= rsp_written_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_avg_ff     <= rsp_avg_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_sel_ff     <= rsp_sel_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.slot_written   = rsp_written_ff;
   assign rsp_ch.slot_index     = rsp_index_ff;
   assign rsp_ch.slot_average   = rsp_avg_ff;
   assign rsp_ch.index_overflow = rsp_ovf_ff;
   assign rsp_ch.scan_done      = rsp_done_ff;
   assign rsp_ch.mux_select     = rsp_sel_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   // scan position never leaves the configured channel range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, pos_ff} < (POS_W + 1)'(CHANNELS)))
      else $error("scan position out of range");

   // a written slot is never also flagged as dropped
   a_write_xor_ovf: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.slot_written) |-> !rsp_ch.index_overflow)
      else $error("response both written and overflowed");

   // the pipeline stays empty for the whole clearing pass
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("request in flight during memory clear");

   // the mux step only moves on the last channel of an enabled scan
   a_mux_step: assert property (@(posedge clock) disable iff (reset)
      (mux_step_ff != mux_step_in) |-> (req_fire && scan_en_ff && scan_end))
      else $error("mux step changed outside scan end");

endmodule

// ===== tb/msa_scan_checker.sv =====
// -----------------------------------------------------------------------------
// msa_scan_checker
// Watches the request, response and register ports of the scan averager. It
// keeps its own copy of the slot rings, running sums and scan counters, works
// out the result each accepted request must produce, and matches every
// accepted response against the oldest outstanding one.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module msa_scan_checker #(
   parameter int CHANNELS  = 16,
   parameter int SIGNALS   = 64,
   parameter int BUF_DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   msa_req_if                               req_ch,
   msa_rsp_if                               rsp_ch,
   input  logic                             csr_we,
   input  logic [msa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               fail_count,
   output int                               pending,
   output int                               checked,
   output int                               slot_writes,
   output int                               overflows,
   output int                               scan_ends
);

   localparam int MUX_WAYS = 8;

   typedef struct packed {
      logic                           slot_written;
      logic [msa_pkg::SLOT_IDX_W-1:0] slot_index;
      logic [msa_pkg::AVG_W-1:0]      slot_average;
      logic                           index_overflow;
      logic                           scan_done;
      logic [msa_pkg::SEL_W-1:0]      mux_select;
   } slot_result_type;

   logic [msa_pkg::AVG_W-1:0]      ring_store [SIGNALS*BUF_DEPTH];
   int                             slot_total [SIGNALS];
   int                             direct_col;
   int                             muxed_col;
   int                             mux_phase;
   int                             scan_pos;
   int                             muxed_count;
   int                             direct_count;
   logic [msa_pkg::CSR_DATA_W-1:0] kind_map;
   logic                           scan_on;
   slot_result_type                expected_results [$];

   // Advance the scan by one reading and return the result it must produce.
   function automatic slot_result_type average_sample(
      input logic [msa_pkg::SAMPLE_W-1:0] raw
   );
      slot_result_type            r;
      logic [msa_pkg::AVG_W-1:0]  value;
      logic [msa_pkg::AVG_W-1:0]  prior;
      logic [msa_pkg::KIND_W-1:0] kind;
      int                         slot;
      int                         col;
      int                         ring_pos;
      r = '0;
      if (!scan_on) return r;
      value = raw[msa_pkg::AVG_W-1:0];
      kind = (scan_pos < msa_pkg::MAP_CHANNELS) ?
             kind_map[msa_pkg::KIND_W*scan_pos +: msa_pkg::KIND_W] : msa_pkg::KIND_UNUSED;
      if (kind == msa_pkg::KIND_DIRECT || kind == msa_pkg::KIND_MUXED) begin
         slot = muxed_count * MUX_WAYS + direct_count;
         if (kind == msa_pkg::KIND_MUXED) begin
            slot += mux_phase;
            col = muxed_col;
            muxed_count++;
         end else begin
            col = direct_col;
            direct_count++;
         end
         if (slot >= SIGNALS || col >= BUF_DEPTH) begin
            r.index_overflow = 1'b1;
         end else begin
            ring_pos = slot * BUF_DEPTH + col;
            prior = ring_store[ring_pos];
            ring_store[ring_pos] = value;
            slot_total[slot] = slot_total[slot] - int'(prior) + int'(value);
            r.slot_written = 1'b1;
            r.slot_index   = msa_pkg::SLOT_IDX_W'(slot);
            r.slot_average = msa_pkg::AVG_W'(slot_total[slot] / BUF_DEPTH);
         end
      end
      if (scan_pos + 1 >= CHANNELS) begin
         scan_pos     = 0;
         muxed_count  = 0;
         direct_count = 0;
         if (mux_phase < int'(msa_pkg::MUX_LAST)) begin
            mux_phase++;
         end else begin
            mux_phase = 0;
            muxed_col = (muxed_col + 1) % BUF_DEPTH;
         end
         direct_col = (direct_col + 1) % BUF_DEPTH;
         r.scan_done  = 1'b1;
         r.mux_select = msa_pkg::SEL_W'(mux_phase);
      end else begin
         scan_pos++;
      end
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      slot_result_type want;
      if (reset) begin
         foreach (ring_store[i]) ring_store[i] = '0;
         foreach (slot_total[i]) slot_total[i] = 0;
         direct_col   = 0;
         muxed_col    = 0;
         mux_phase    = 0;
         scan_pos     = 0;
         muxed_count  = 0;
         direct_count = 0;
         kind_map     = '0;
         scan_on      = 1'b1;
         expected_results.delete();
         fail_count   = 0;
         checked      = 0;
         slot_writes  = 0;
         overflows    = 0;
         scan_ends    = 0;
      end else begin
         // a response never belongs to a request taken at the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("slot_written", want.slot_written, rsp_ch.slot_written);
               compare_field("slot_index", want.slot_index, rsp_ch.slot_index);
               compare_field("slot_average", want.slot_average, rsp_ch.slot_average);
               compare_field("index_overflow", want.index_overflow,
                             rsp_ch.index_overflow);
               compare_field("scan_done", want.scan_done, rsp_ch.scan_done);
               compare_field("mux_select", want.mux_select, rsp_ch.mux_select);
               checked++;
               slot_writes += want.slot_written;
               overflows   += want.index_overflow;
               scan_ends   += want.scan_done;
            end
         end
         if (csr_we) begin
            case (csr_index)
               msa_pkg::CSR_KIND_MAP:    kind_map = csr_wdata;
               msa_pkg::CSR_SCAN_ENABLE: scan_on  = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_results.push_back(average_sample(req_ch.raw_sample));
      end
      pending = expected_results.size();
   end

endmodule

// ===== tb/muxed_adc_scan_averager_test.sv =====
// -----------------------------------------------------------------------------
// muxed_adc_scan_averager_test
// Drives converter readings through the scan averager under a series of channel
// kind maps, with random gaps on both handshakes, one long response hold-off
// and two stretches with scanning switched off. A checker beside the block predicts
// every response and counts mismatches; this module only makes stimulus and
// gives the verdict.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module muxed_adc_scan_averager_test;

   localparam int CHANNELS      = 16;
   localparam int SIGNALS       = 64;
   localparam int BUF_DEPTH     = 8;
   localparam int RANDOM_PHASES = 10;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [msa_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [msa_pkg::CSR_DATA_W-1:0] csr_wdata;

   msa_req_if req_ch ();
   msa_rsp_if rsp_ch ();

   int   fail_count;
   int   pending;
   int   checked;
   int   slot_writes;
   int   overflows;
   int   scan_ends;
   int   samples_sent;
   int   samples_ignored;
   int   maps_used;
   logic steady;           // no gaps on either side while set
   logic long_hold_armed;  // ask the response side for one long hold-off

   muxed_adc_scan_averager #(
      .CHANNELS  (CHANNELS),
      .SIGNALS   (SIGNALS),
      .BUF_DEPTH (BUF_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   msa_scan_checker #(
      .CHANNELS  (CHANNELS),
      .SIGNALS   (SIGNALS),
      .BUF_DEPTH (BUF_DEPTH)
   ) slot_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .slot_writes (slot_writes),
      .overflows   (overflows),
      .scan_ends   (scan_ends)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop. The slowest legal run is a clearing pass over the whole ring
   // plus at most about 830 requests, each facing the longest sender gap and
   // the longest response stall, plus one long hold-off: about 200 us.
   // Allow about ten times that.
   initial begin : watchdog
      #2000000;
      $display("FAIL muxed_adc_scan_averager");
      $finish;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Random reading, with the masking boundaries thrown in now and then.
   function automatic logic [msa_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         2:       return 12'h3FF;
         3:       return 12'h400;
         default: return msa_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   // Response side: stall at random, and once hold ready low for a long
   // stretch so the pipeline fills and the block drops its request ready.
   initial begin : response_sink
      int stall_left;
      bit long_hold_done;
      rsp_ch.ready   = 1'b0;
      stall_left     = 0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_armed && !long_hold_done) begin
            stall_left     = 80;
            long_hold_done = 1'b1;
         end else if (stall_left == 0 && !steady) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until the block takes it. Called right after
   // an accepting edge (or from idle), so valid only drops when a gap is due.
   task automatic send_sample(input logic [msa_pkg::SAMPLE_W-1:0] value);
      int gap;
      gap = steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.raw_sample <= value;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      samples_sent++;
   endtask

   // Drop valid and wait until every outstanding request has its response.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [msa_pkg::CSR_IDX_W-1:0] index,
                            input logic [msa_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      logic [msa_pkg::SAMPLE_W-1:0]   corner_samples [16];
      logic [msa_pkg::CSR_DATA_W-1:0] kind_map_value;
      int                             count;

      // Hold every input at a known value, reset included.
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = msa_pkg::CSR_KIND_MAP;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.raw_sample = '0;
      steady            = 1'b0;
      long_hold_armed   = 1'b0;
      samples_sent      = 0;
      samples_ignored   = 0;
      maps_used         = 0;
      corner_samples = '{12'h000, 12'hFFF, 12'h3FF, 12'h400, 12'hC00, 12'h5A5,
                         12'hA5A, 12'h001, 12'h200, 12'h7FF, 12'h800, 12'h3FE,
                         12'hFFF, 12'h000, 12'h155, 12'hEAA};

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed scan. Channel kinds, channel 0 first:
      //   direct, muxed, kind 3, unused, seven muxed, then direct, muxed,
      //   direct, kind 3, muxed.
      // The seven muxed channels land just under slot 64; everything after
      // them computes a slot past the store and must be dropped and flagged.
      write_csr(msa_pkg::CSR_KIND_MAP, 32'hB66A_AA39);
      maps_used++;
      foreach (corner_samples[i]) send_sample(corner_samples[i]);
      settle();

      // Scanning off: requests are taken but change nothing.
      write_csr(msa_pkg::CSR_SCAN_ENABLE, 32'd0);
      repeat (4) send_sample(pick_sample());
      samples_ignored += 4;
      settle();
      write_csr(msa_pkg::CSR_SCAN_ENABLE, 32'd1);

      // Random phases, each under its own kind map. Slots are shared between
      // maps, so rings carry old samples from one phase into the next.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       kind_map_value = 32'h5555_5555;  // all direct
            1:       kind_map_value = 32'hAAAA_AAAA;  // all muxed, upper half drops
            3:       kind_map_value = 32'h0000_0000;  // all unused
            4:       kind_map_value = 32'hFFFF_FFFF;  // all kind 3
            5:       kind_map_value = 32'h0000_AAAA;  // eight muxed, rest unused
            default: kind_map_value = $urandom;
         endcase
         write_csr(msa_pkg::CSR_KIND_MAP, kind_map_value);
         maps_used++;
         steady <= (phase == 1 || phase == 2 || phase == 7);
         if (phase == 2)
            long_hold_armed <= 1'b1;
         count = CHANNELS * $urandom_range(2, 5);
         repeat (count) send_sample(pick_sample());
         settle();

         // Switch scanning off between scans, then resume where it left off.
         if (phase == 6) begin
            write_csr(msa_pkg::CSR_SCAN_ENABLE, 32'd0);
            repeat (8) send_sample(pick_sample());
            samples_ignored += 8;
            settle();
            write_csr(msa_pkg::CSR_SCAN_ENABLE, 32'd1);
         end
      end

      // Give any stray response time to show up.
      repeat (8) @(negedge clock);

      $display("Covered %0d samples under %0d kind maps plus %0d with scanning off.",
               samples_sent - samples_ignored, maps_used, samples_ignored);
      $display("Checked %0d responses: %0d slot writes, %0d overflow drops, %0d scan ends.",
               checked, slot_writes, overflows, scan_ends);
      if (fail_count == 0 && pending == 0)
         $display("PASS muxed_adc_scan_averager");
      else
         $display("FAIL muxed_adc_scan_averager");
      $finish;
   end

endmodule
